// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion wrappers for the decoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, skipped while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Types and constants shared by the base64 stream decoder modules.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] END_CHAR_RESET = 8'd41;  // ')'
  localparam int unsigned MAX_RESULTS = 3;

  // register index taken from the byte address
  localparam logic REG_END_CHAR = 1'b0;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_EARLY_END = 2'd0,
    ERR_FORBIDDEN = 2'd1,
    ERR_AFTER_PAD = 2'd2,
    ERR_LONE      = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    err_t       code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;   // sextets gathered
    logic       pad;   // reading '=' padding
    logic [2:0] gtot;  // sextets plus '=' in a padded group
    logic [1:0] dig;   // sextets of the padded group
  } dec_state_t;

  typedef struct packed {
    logic [1:0]                  n;
    res_t [MAX_RESULTS-1:0]      res;
    dec_state_t                  st_nxt;
    logic                        wr_en;
    logic [1:0]                  wr_idx;
    logic [5:0]                  wr_val;
  } step_t;

endpackage

// ----- design/b64d_core.sv -----
// ----------------------------------------------------------------------------
// b64d_core
// One decode step: classifies a character, updates the group state and
// builds the up to three results that the character causes.
// ----------------------------------------------------------------------------
module b64d_core (
  input  logic [7:0]         char_in,
  input  logic               input_over,
  input  logic [7:0]         end_char,
  input  b64d_pkg::dec_state_t st,
  input  logic [2:0][5:0]    store,
  output b64d_pkg::step_t    step
);
  import b64d_pkg::*;

  typedef struct packed {
    logic       is_sext;
    logic       is_ign;
    logic [5:0] val;
  } cls_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r = '0;
    if (c >= "A" && c <= "Z") begin
      r.is_sext = 1'b1;
      r.val     = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      r.is_sext = 1'b1;
      r.val     = 6'(c - "a" + 8'd26);
    end else if (c >= "0" && c <= "9") begin
      r.is_sext = 1'b1;
      r.val     = 6'(c - "0" + 8'd52);
    end else if (c == "+") begin
      r.is_sext = 1'b1;
      r.val     = 6'd62;
    end else if (c == "/") begin
      r.is_sext = 1'b1;
      r.val     = 6'd63;
    end else if (c < 8'd32 || c == " " || c == 8'h7f) begin
      r.is_ign  = 1'b1;
    end
    return r;
  endfunction

  // bytes that a partial group of k sextets yields
  function automatic logic [1:0] part_bytes(input logic [1:0] k);
    return (k >= 2'd2) ? 2'(k - 2'd1) : 2'd0;
  endfunction

  cls_t       cls;
  logic       is_end;
  logic       is_pad;
  logic [2:0] gt_inc;
  logic [1:0] eb;
  logic       term;
  kind_t      tkind;
  err_t       tcode;
  logic [2:0][7:0] bytes;

  always_comb begin
    cls    = classify(char_in);
    is_end = (char_in == end_char);
    is_pad = (char_in == "=");
    gt_inc = 3'(st.gtot + 3'd1);
    bytes[0] = {store[0], store[1][5:4]};
    bytes[1] = {store[1][3:0], store[2][5:2]};
    bytes[2] = {store[2][1:0], cls.val};

    step.st_nxt = st;
    step.wr_en  = 1'b0;
    step.wr_idx = st.cnt;
    step.wr_val = cls.val;
    eb    = 2'd0;
    term  = 1'b0;
    tkind = KIND_DONE;
    tcode = ERR_EARLY_END;

    if (st.pad) begin
      if (input_over) begin
        eb = part_bytes(st.dig);
        term = 1'b1;
        tkind = KIND_ERR;
        step.st_nxt = '0;
      end else if (is_end) begin
        eb = part_bytes(st.dig);
        term = 1'b1;
        step.st_nxt = '0;
      end else if (cls.is_ign) begin
        step.st_nxt = st;
      end else if (is_pad) begin
        if (gt_inc >= 3'd4) begin
          eb = part_bytes(st.dig);
          step.st_nxt = '0;
        end else begin
          step.st_nxt.gtot = gt_inc;
        end
      end else begin
        term = 1'b1;
        tkind = KIND_ERR;
        tcode = ERR_AFTER_PAD;
        step.st_nxt = '0;
      end
    end else if (input_over) begin
      term = 1'b1;
      tkind = KIND_ERR;
      step.st_nxt = '0;
    end else if (is_end || is_pad) begin
      if (st.cnt == 2'd1) begin
        term = 1'b1;
        tkind = KIND_ERR;
        tcode = ERR_LONE;
        step.st_nxt = '0;
      end else if (is_end) begin
        eb = part_bytes(st.cnt);
        term = 1'b1;
        step.st_nxt = '0;
      end else if (st.cnt == 2'd3) begin
        // '=' closes a three-sextet group at once
        eb = 2'd2;
        step.st_nxt = '0;
      end else begin
        step.st_nxt.dig  = st.cnt;
        step.st_nxt.gtot = 3'({1'b0, st.cnt} + 3'd1);
        step.st_nxt.cnt  = 2'd0;
        step.st_nxt.pad  = 1'b1;
      end
    end else if (cls.is_ign) begin
      step.st_nxt = st;
    end else if (!cls.is_sext) begin
      term = 1'b1;
      tkind = KIND_ERR;
      tcode = ERR_FORBIDDEN;
      step.st_nxt = '0;
    end else if (st.cnt == 2'd3) begin
      eb = 2'd3;
      step.st_nxt.cnt = 2'd0;
    end else begin
      step.wr_en = 1'b1;
      step.st_nxt.cnt = 2'(st.cnt + 2'd1);
    end

    step.n = 2'(eb + {1'b0, term});
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < eb) begin
        step.res[i].data = bytes[i];
        step.res[i].kind = KIND_DATA;
        step.res[i].code = ERR_EARLY_END;
      end else begin
        step.res[i].data = 8'd0;
        step.res[i].kind = tkind;
        step.res[i].code = tcode;
      end
      step.res[i].last = (2'(i) == 2'(step.n - 2'd1));
    end
  end

endmodule

// ----- design/base64_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming base64 decoder: one character in, data bytes and status out.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake           | payload
//  in_       | in  | in_tvalid/in_tready | tdata: char_in, tuser: input_over
//  out_      | out | out_tvalid/tready   | tdata: out_byte, tuser: kind, code
//  cfg_      | in  | APB, pready high    | reg 0 end_char at byte address 0
//
// An accepted item is decoded from the input register; its results (up to
// three) load the result register on advance and leave one per ready cycle.
// A group of four characters gives three bytes, so at full flow one character
// is taken every cycle while the bytes drain. Reset is synchronous; it clears
// the group state and empties both registers. A stalled output holds its item
// and stalls input only when the next item has results of its own.
module base64_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic [0:0]  in_tuser,   // [0] input_over
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [3:0]  out_tuser,  // [1:0] kind, [3:2] error_code
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import b64d_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_over_r;
  logic [7:0] end_char_r;
  dec_state_t st_r;
  logic [2:0][5:0] store_r;
  res_t [MAX_RESULTS-1:0] res_r;
  logic [1:0] rem_r;
  logic [1:0] ptr_r;

  step_t step;
  logic  advance;
  logic  free_nxt;
  logic  out_take;
  logic  cfg_wr;
  res_t  cur;

  b64d_core u_core (
    .char_in    (in_char_r),
    .input_over (in_over_r),
    .end_char   (end_char_r),
    .st         (st_r),
    .store      (store_r),
    .step       (step)
  );

  assign out_take  = out_tvalid && out_tready;
  assign free_nxt  = (rem_r == 2'd0) || (rem_r == 2'd1 && out_tready);
  assign advance   = in_valid_r && ((step.n == 2'd0) || free_nxt);
  assign in_tready = !in_valid_r || advance;

  assign cur        = res_r[ptr_r];
  assign out_tvalid = (rem_r != 2'd0);
  assign out_tdata  = cur.data;
  assign out_tuser  = {cur.code, cur.kind};
  assign out_tlast  = cur.last;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_END_CHAR) ? {24'd0, end_char_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      st_r       <= '0;
      rem_r      <= 2'd0;
      ptr_r      <= 2'd0;
      end_char_r <= END_CHAR_RESET;
    end else begin
      if (cfg_wr && cfg_paddr[2] == REG_END_CHAR) begin
        end_char_r <= cfg_pwdata[7:0];
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        st_r <= step.st_nxt;
      end
      if (advance && step.n != 2'd0) begin
        rem_r <= step.n;
        ptr_r <= 2'd0;
      end else if (out_take) begin
        rem_r <= 2'(rem_r - 2'd1);
        ptr_r <= 2'(ptr_r + 2'd1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_char_r <= in_tdata;
      in_over_r <= in_tuser[0];
    end
    if (advance && step.wr_en) begin
      store_r[step.wr_idx] <= step.wr_val;
    end
    if (advance && step.n != 2'd0) begin
      res_r <= step.res;
    end
  end

endmodule

// ----- design/b64d_checker.sv -----
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the decoder result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [3:0] out_tuser,
  input logic       out_tlast
);
  import b64d_pkg::*;

  // a stalled item holds
  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)), "output item changed while stalled")

  // finish and error results close the burst of their item and carry no byte
  `ASSERT_CLK(a_status_last, clk, rst_n, (out_tvalid && out_tuser[1:0] != KIND_DATA |-> out_tlast && out_tdata == 8'd0), "status result not last or has data")

  // data bytes carry no error code, and kind 3 never shows
  `ASSERT_CLK(a_kind_code, clk, rst_n, (out_tvalid |-> out_tuser[1:0] != 2'd3 && (out_tuser[1:0] != KIND_DATA || out_tuser[3:2] == ERR_EARLY_END)), "bad kind or code")

  // reset empties the result register
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, (!rst_n |=> !out_tvalid), "output valid after reset")

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
